/* rtl/adaptive_range_encoder_top_macros.svh */
// Assertion macros used by the adaptive range encoder checker.
`ifndef ADAPTIVE_RANGE_ENCODER_TOP_MACROS_SVH
`define ADAPTIVE_RANGE_ENCODER_TOP_MACROS_SVH

// Check a property at every rising edge, masked while reset is high.
`define ARE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge, reset cycles included.
`define ARE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/are_pkg.sv */
// Package: types, constants and codes of the adaptive range encoder.
package are_pkg;

   localparam int NUM_CONTEXTS_DEF = 4;
   localparam int MAX_SYMBOLS_DEF  = 256;

   localparam int COUNT_W = 17;
   localparam int TOTAL_W = 18;
   localparam int CSR_W   = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 18'd256;
   localparam logic [31:0]        RANGE_TOP   = 32'h0100_0000;
   localparam logic [8:0]         TOP_FF      = 9'h0FF;
   localparam logic [2:0]         NORM_SHIFTS = 3'd4;
   localparam logic [2:0]         FLUSH_SHIFTS = 3'd5;

   localparam logic [1:0] OP_ENCODE = 2'd0;
   localparam logic [1:0] OP_INIT   = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   localparam logic [1:0] REG_SYMBOLS_IN_USE  = 2'd0;
   localparam logic [1:0] REG_COUNT_INCREMENT = 2'd1;
   localparam logic [1:0] REG_RESCALE_LIMIT   = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] context_req;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [31:0] fill_count;
      logic        fill_is_zero;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic init_step;
      logic init_done;
      logic sum_issue;
      logic div_start;
      logic div_step;
      logic mul1;
      logic mul2;
      logic rng;
      logic flush_add;
      logic shift;
      logic push_last;
      logic upd;
      logic rsc_issue;
      logic rsc_total;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_op;
      logic       req_ctx_ok;
      logic [1:0] op;
      logic       clear_done;
      logic       idx_at_sym;
      logic       idx_at_max;
      logic       idx_at_nlast;
      logic       div_done;
      logic       shift_more;
      logic       emits;
      logic       hold_valid;
      logic       out_free;
      logic       need_rescale;
   } sts_type;

endpackage

/* rtl/adaptive_range_encoder_top.sv */
// Top level of the adaptive range encoder: controller plus datapath.
// Encode holds req_ready low through the count walk, the divider, two multiplies and up
//   to four shifts that wait on a full output, plus an alphabet pass when rescaling.
// Throughput: one transaction at a time; init sets all MAX_SYMBOLS counts of its context
//   to one, and flush adds one to low and then shifts five times. Reset: synchronous; then
//   a clearing pass over every count memory address sets every count to one, req_ready low.
module adaptive_range_encoder_top
   import are_pkg::*;
#(
   parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
   parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   // command and status between controller and datapath
   cmd_type cmd;
   sts_type sts;

   // sequence each transaction: walk, divide, scale, renormalize, adapt
   are_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the coder state, the count memory and the output register
   are_datapath #(
      .NUM_CONTEXTS (NUM_CONTEXTS),
      .MAX_SYMBOLS  (MAX_SYMBOLS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/are_datapath.sv */
// Datapath: coder registers, count memory, divider, multiplier and output stage.
module are_datapath
   import are_pkg::*;
#(
   parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
   parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_payload,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  cmd_type          cmd,
   output sts_type          sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload
);

   localparam int SYM_W  = $clog2(MAX_SYMBOLS);
   localparam int CTX_W  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
   localparam int ADDR_W = CTX_W + SYM_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int SUM_W  = COUNT_W + SYM_W;
   localparam int PROD_W = SUM_W + 32;
   localparam logic [8:0] MAX9 = 9'(MAX_SYMBOLS);

   // configuration
   logic [8:0]         siu_ff;
   logic [7:0]         inc_ff;
   logic [16:0]        limit_ff;

   // item
   logic [1:0]         op_ff;
   logic [CTX_W-1:0]   ctx_ff;
   logic [SYM_W-1:0]   sym_ff;

   // coder state
   logic [32:0]        low_ff;
   logic [31:0]        range_ff;
   logic [7:0]         cached_ff;
   logic [31:0]        pend_ff;
   logic [TOTAL_W-1:0] total_ff [NUM_CONTEXTS];

   // memory and walk
   logic [COUNT_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;
   logic               rd_val_ff;
   logic               rd_rsc_ff;
   logic               rd_last_ff;
   logic [SYM_W-1:0]   rd_idx_ff;
   logic [SYM_W-1:0]   idx_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic [SUM_W-1:0]   cum_ff;
   logic [SUM_W-1:0]   rsum_ff;
   logic [COUNT_W-1:0] cnt_sym_ff;

   // divider and multiplier
   logic [31:0]        dvd_ff;
   logic [TOTAL_W:0]   rem_ff;
   logic [TOTAL_W-1:0] dvs_ff;
   logic [31:0]        q_ff;
   logic [4:0]         div_cnt_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [2:0]         sh_cnt_ff;

   // output
   logic               hold_valid_ff;
   rsp_type            hold_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [8:0]         n_sym;
   logic [8:0]         sym9;
   logic [8:0]         sym_eff;
   logic [TOTAL_W-1:0] tot_sel;
   logic [COUNT_W-1:0] halved;
   logic [COUNT_W:0]   cnt_inc;
   logic [TOTAL_W:0]   tot_inc;
   logic [TOTAL_W:0]   trial;
   logic [8:0]         top9;
   logic               carry;
   logic               push;
   logic               we;
   logic [ADDR_W-1:0]  wa;
   logic [COUNT_W-1:0] wd;

   always_comb begin
      if (siu_ff < 9'd2) begin
         n_sym = 9'd2;
      end else if (siu_ff > MAX9) begin
         n_sym = MAX9;
      end else begin
         n_sym = siu_ff;
      end
      sym9    = {1'b0, req_payload.symbol};
      sym_eff = (sym9 >= n_sym) ? n_sym - 9'd1 : sym9;
   end

   assign tot_sel = total_ff[ctx_ff];
   assign halved  = (rd_data_ff >> 1) + COUNT_W'(1);
   assign cnt_inc = {1'b0, cnt_sym_ff} + (COUNT_W+1)'(inc_ff);
   assign tot_inc = {1'b0, tot_sel} + (TOTAL_W+1)'(inc_ff);
   assign trial   = {rem_ff[TOTAL_W-1:0], dvd_ff[31]};
   assign top9    = low_ff[32:24];
   assign carry   = top9[8];
   assign push    = (cmd.shift && sts.emits && hold_valid_ff) || cmd.push_last;

   always_comb begin
      sts.req_op       = req_payload.operation;
      sts.req_ctx_ok   = 7'(req_payload.context_req) < 7'(NUM_CONTEXTS);
      sts.op           = op_ff;
      sts.clear_done   = (clr_ff == ADDR_W'(DEPTH - 1));
      sts.idx_at_sym   = (idx_ff == sym_ff);
      sts.idx_at_max   = (idx_ff == SYM_W'(MAX_SYMBOLS - 1));
      sts.idx_at_nlast = (9'(idx_ff) == n_sym - 9'd1);
      sts.div_done     = (div_cnt_ff == 5'd31);
      sts.shift_more   = (op_ff == OP_FLUSH) ? (sh_cnt_ff < FLUSH_SHIFTS)
                         : ((sh_cnt_ff < NORM_SHIFTS) && (range_ff < RANGE_TOP));
      sts.emits        = (top9 != TOP_FF);
      sts.hold_valid   = hold_valid_ff;
      sts.out_free     = !rsp_valid_ff || rsp_ready;
      sts.need_rescale = 18'(limit_ff) < tot_sel;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         siu_ff   <= 9'd256;
         inc_ff   <= 8'd1;
         limit_ff <= 17'd65536;
      end else if (csr_we) begin
         case (csr_index)
            REG_SYMBOLS_IN_USE:  siu_ff   <= csr_wdata[8:0];
            REG_COUNT_INCREMENT: inc_ff   <= csr_wdata[7:0];
            REG_RESCALE_LIMIT:   limit_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // count memory write port
   always_comb begin
      we = 1'b0;
      wa = {ctx_ff, sym_ff};
      wd = COUNT_W'(1);
      if (cmd.clear_step) begin
         we = 1'b1;
         wa = clr_ff;
      end else if (cmd.init_step) begin
         we = 1'b1;
         wa = {ctx_ff, idx_ff};
      end else if (cmd.upd) begin
         we = 1'b1;
         wd = cnt_inc[COUNT_W] ? COUNT_MAX : cnt_inc[COUNT_W-1:0];
      end else if (rd_val_ff && rd_rsc_ff) begin
         we = 1'b1;
         wa = {ctx_ff, rd_idx_ff};
         wd = halved;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[{ctx_ff, idx_ff}];
   end

   // walk control
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         rd_val_ff  <= 1'b0;
         rd_rsc_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         rd_val_ff  <= cmd.sum_issue || cmd.rsc_issue;
         rd_rsc_ff  <= cmd.rsc_issue;
         rd_last_ff <= cmd.sum_issue && sts.idx_at_sym;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (cmd.load) begin
         op_ff   <= req_payload.operation;
         ctx_ff  <= CTX_W'(req_payload.context_req);
         sym_ff  <= sym_eff[SYM_W-1:0];
         idx_ff  <= '0;
         cum_ff  <= '0;
         rsum_ff <= '0;
      end else begin
         // rewind the walk so a rescale starts at the first symbol
         if (cmd.upd) begin
            idx_ff <= '0;
         end else if (cmd.sum_issue || cmd.rsc_issue || cmd.init_step) begin
            idx_ff <= idx_ff + SYM_W'(1);
         end
         if (rd_val_ff && !rd_rsc_ff) begin
            if (rd_last_ff) begin
               cnt_sym_ff <= rd_data_ff;
            end else begin
               cum_ff <= cum_ff + SUM_W'(rd_data_ff);
            end
         end
         if (rd_val_ff && rd_rsc_ff) begin
            rsum_ff <= rsum_ff + SUM_W'(halved);
         end
      end
   end

   // shift-subtract divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff     <= range_ff;
         rem_ff     <= '0;
         dvs_ff     <= (tot_sel == '0) ? TOTAL_W'(1) : tot_sel;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_ff <= trial - {1'b0, dvs_ff};
            q_ff   <= {q_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial;
            q_ff   <= {q_ff[30:0], 1'b0};
         end
         dvd_ff     <= {dvd_ff[30:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end
      if (cmd.mul1) begin
         prod_ff <= PROD_W'(cum_ff) * PROD_W'(q_ff);
      end else if (cmd.mul2) begin
         prod_ff <= PROD_W'(cnt_sym_ff) * PROD_W'(q_ff);
      end
   end

   // coder state
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= '0;
         range_ff  <= '1;
         cached_ff <= '0;
         pend_ff   <= '0;
         sh_cnt_ff <= '0;
         for (int c = 0; c < NUM_CONTEXTS; c++) begin
            total_ff[c] <= TOTAL_RESET;
         end
      end else begin
         if (cmd.load) begin
            sh_cnt_ff <= '0;
         end
         if (cmd.mul2) begin
            low_ff <= low_ff + prod_ff[32:0];
         end
         if (cmd.rng) begin
            range_ff <= (|prod_ff[PROD_W-1:32]) ? '1 : prod_ff[31:0];
         end
         if (cmd.flush_add) begin
            low_ff <= low_ff + 33'd1;
         end
         if (cmd.shift) begin
            sh_cnt_ff <= sh_cnt_ff + 3'd1;
            low_ff    <= {1'b0, low_ff[23:0], 8'h00};
            if (op_ff == OP_ENCODE) begin
               range_ff <= {range_ff[23:0], 8'h00};
            end
            if (sts.emits) begin
               pend_ff   <= '0;
               cached_ff <= top9[7:0];
            end else if (pend_ff != '1) begin
               pend_ff <= pend_ff + 32'd1;
            end
         end
         if (cmd.init_done) begin
            total_ff[ctx_ff] <= TOTAL_W'(n_sym);
         end
         if (cmd.upd) begin
            total_ff[ctx_ff] <= tot_inc[TOTAL_W] ? TOTAL_MAX : tot_inc[TOTAL_W-1:0];
         end
         if (cmd.rsc_total) begin
            total_ff[ctx_ff] <= (rsum_ff > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                : rsum_ff[TOTAL_W-1:0];
         end
      end
   end

   // held result and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.shift && sts.emits) begin
            hold_valid_ff <= 1'b1;
         end else if (cmd.push_last) begin
            hold_valid_ff <= 1'b0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift && sts.emits) begin
         hold_ff.out_byte     <= cached_ff + {7'd0, carry};
         hold_ff.fill_count   <= pend_ff;
         hold_ff.fill_is_zero <= (pend_ff != '0) && carry;
         hold_ff.last         <= 1'b0;
      end
      // mark the final result of the transaction as it moves out
      if (push) begin
         rsp_ff <= {hold_ff[$bits(rsp_type)-1:1], cmd.push_last};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/are_ctrl.sv */
// Controller: sequences the clearing pass and every step of one transaction.
module are_ctrl
   import are_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_INIT  = 5'd2;
   localparam logic [4:0] S_SUM   = 5'd3;
   localparam logic [4:0] S_SUMW  = 5'd4;
   localparam logic [4:0] S_DIV   = 5'd5;
   localparam logic [4:0] S_MUL1  = 5'd6;
   localparam logic [4:0] S_MUL2  = 5'd7;
   localparam logic [4:0] S_RNG   = 5'd8;
   localparam logic [4:0] S_FLUSH = 5'd9;
   localparam logic [4:0] S_NORM  = 5'd10;
   localparam logic [4:0] S_FIN   = 5'd11;
   localparam logic [4:0] S_UPD   = 5'd12;
   localparam logic [4:0] S_CHK   = 5'd13;
   localparam logic [4:0] S_RSC   = 5'd14;
   localparam logic [4:0] S_RSCW  = 5'd15;
   localparam logic [4:0] S_RSCT  = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.req_ctx_ok) begin
                  case (sts.req_op)
                     OP_ENCODE: state_in = S_SUM;
                     OP_INIT:   state_in = S_INIT;
                     OP_FLUSH:  state_in = S_FLUSH;
                     default:   state_in = S_IDLE;
                  endcase
               end
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.idx_at_max) begin
               cmd.init_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SUM: begin
            cmd.sum_issue = 1'b1;
            if (sts.idx_at_sym) state_in = S_SUMW;
         end
         S_SUMW: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_RNG;
         end
         S_RNG: begin
            cmd.rng  = 1'b1;
            state_in = S_NORM;
         end
         S_FLUSH: begin
            cmd.flush_add = 1'b1;
            state_in      = S_NORM;
         end
         S_NORM: begin
            if (!sts.shift_more) begin
               state_in = S_FIN;
            end else if (!(sts.emits && sts.hold_valid && !sts.out_free)) begin
               cmd.shift = 1'b1;
            end
         end
         S_FIN: begin
            if (!sts.hold_valid || sts.out_free) begin
               cmd.push_last = sts.hold_valid;
               state_in      = (sts.op == OP_ENCODE) ? S_UPD : S_IDLE;
            end
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = sts.need_rescale ? S_RSC : S_IDLE;
         end
         S_RSC: begin
            cmd.rsc_issue = 1'b1;
            if (sts.idx_at_nlast) state_in = S_RSCW;
         end
         S_RSCW: begin
            state_in = S_RSCT;
         end
         S_RSCT: begin
            cmd.rsc_total = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/are_checker.sv */
// Checker on the top-level ports of the adaptive range encoder, with its bind.
`include "adaptive_range_encoder_top_macros.svh"

module are_checker
   import are_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   `ARE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `ARE_ASSERT(a_fill_kind, clock, reset, rsp_valid && rsp_payload.fill_count == 32'd0 |-> !rsp_payload.fill_is_zero, "empty fill marked zero")
   `ARE_ASSERT_ALWAYS(a_reset_out, clock, reset |=> !rsp_valid, "rsp valid after reset")
   `ARE_ASSERT_ALWAYS(a_clear_busy, clock, $fell(reset) |-> !req_ready, "ready during clearing pass")

endmodule

bind adaptive_range_encoder_top are_checker u_are_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
